// ----- hw/rtl/servo_command_packet_parser_top_defines.svh -----
// Assertion macros shared by the servo command packet parser RTL.
`ifndef SERVO_COMMAND_PACKET_PARSER_TOP_DEFINES_SVH
`define SERVO_COMMAND_PACKET_PARSER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Clocked assertion, disabled while reset is asserted.
`define SCPP_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("scpp assertion failed");
// Clocked assertion that is also checked during reset.
`define SCPP_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("scpp assertion failed");
`else
`define SCPP_ASSERT(label, clk, rst_n, prop)
`define SCPP_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- hw/rtl/scpp_pkg.sv -----
// Package: frame constants, pulse limits and shared types of the servo command parser.
`default_nettype none
package scpp_pkg;
	localparam logic [7:0] FRAME_HEADER = 8'hAA;
	localparam logic [7:0] FRAME_TYPE   = 8'h01;
	localparam logic [7:0] FRAME_TAIL   = 8'h55;

	localparam int PULSE_W = 11;
	localparam int CALC_W  = 13;

	localparam logic signed [CALC_W-1:0] PULSE_MID  = 13'sd1500;
	localparam logic signed [CALC_W-1:0] PULSE1_MIN = 13'sd1000;
	localparam logic signed [CALC_W-1:0] PULSE1_MAX = 13'sd1900;
	localparam logic signed [CALC_W-1:0] PULSE2_MIN = 13'sd1000;
	localparam logic signed [CALC_W-1:0] PULSE2_MAX = 13'sd2000;
	localparam logic signed [CALC_W-1:0] PULSE_STEP = 13'sd50;
	localparam logic signed [CALC_W-1:0] COL_LIMIT  = 13'sd8;
	localparam logic signed [CALC_W-1:0] ROW_LIMIT  = 13'sd10;

	// Outcome of the frame tracker for the byte in stage 1.
	typedef struct packed {
		logic       ok;
		logic [7:0] column;
		logic [7:0] row;
	} frame_res_t;
endpackage
`default_nettype wire

// ----- hw/rtl/scpp_frame.sv -----
// Frame tracker: byte position, captured frame bytes and the end-of-frame check.
`default_nettype none
`include "servo_command_packet_parser_top_defines.svh"
module scpp_frame (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic [7:0]           rx_byte,
	output scpp_pkg::frame_res_t      res
);
	typedef enum logic [2:0] {
		POS_HDR  = 3'd0,
		POS_TYPE = 3'd1,
		POS_COL  = 3'd2,
		POS_ROW  = 3'd3,
		POS_CHK  = 3'd4,
		POS_TAIL = 3'd5
	} pos_t;

	pos_t       pos_q, pos_d;
	logic [7:0] column_q;
	logic [7:0] row_q;
	logic [7:0] check_q;
	logic [7:0] sum;
	logic       at_tail;

	assign sum = scpp_pkg::FRAME_HEADER + scpp_pkg::FRAME_TYPE + column_q + row_q;

	always_comb begin
		at_tail = 1'b0;
		pos_d   = pos_q;
		unique case (pos_q)
			POS_HDR: begin
				if (rx_byte == scpp_pkg::FRAME_HEADER) pos_d = POS_TYPE;
			end
			POS_TYPE: begin
				if (rx_byte == scpp_pkg::FRAME_TYPE) pos_d = POS_COL;
				else if (rx_byte == scpp_pkg::FRAME_HEADER) pos_d = POS_TYPE;
				else pos_d = POS_HDR;
			end
			POS_COL: pos_d = POS_ROW;
			POS_ROW: pos_d = POS_CHK;
			POS_CHK: pos_d = POS_TAIL;
			default: begin
				// tail byte, and any unused code: close the frame
				at_tail = 1'b1;
				pos_d   = POS_HDR;
			end
		endcase
	end

	assign res.ok     = at_tail && (rx_byte == scpp_pkg::FRAME_TAIL) && (sum == check_q);
	assign res.column = column_q;
	assign res.row    = row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= POS_HDR;
			column_q <= '0;
			row_q    <= '0;
			check_q  <= '0;
		end else if (en) begin
			pos_q <= pos_d;
			if (pos_q == POS_COL) column_q <= rx_byte;
			if (pos_q == POS_ROW) row_q <= rx_byte;
			if (pos_q == POS_CHK) check_q <= rx_byte;
		end
	end

	`SCPP_ASSERT(a_ok_restarts, clk, arst_n, (en && res.ok) |=> (pos_q == POS_HDR))
	`SCPP_ASSERT(a_hdr_opens, clk, arst_n, (en && pos_q == POS_HDR && rx_byte == scpp_pkg::FRAME_HEADER) |=> (pos_q == POS_TYPE))
	`SCPP_ASSERT_ALWAYS(a_reset_pos, clk, !arst_n |-> (pos_q == POS_HDR))
endmodule
`default_nettype wire

// ----- hw/rtl/scpp_pulse.sv -----
// Pulse mapper: column and row bytes to the two servo pulse widths.
`default_nettype none
module scpp_pulse (
	input  wire logic [7:0]                    column,
	input  wire logic [7:0]                    row,
	output logic [scpp_pkg::PULSE_W-1:0]       servo1_pulse,
	output logic [scpp_pkg::PULSE_W-1:0]       servo2_pulse
);
	logic signed [scpp_pkg::CALC_W-1:0] col_x, row_x, col_c, row_c;
	logic signed [scpp_pkg::CALC_W-1:0] p1, p2, p1_c, p2_c;

	assign col_x = {{(scpp_pkg::CALC_W-8){column[7]}}, column};
	assign row_x = {{(scpp_pkg::CALC_W-8){row[7]}}, row};

	always_comb begin
		// clamp the offsets before scaling
		if (col_x < -scpp_pkg::COL_LIMIT) col_c = -scpp_pkg::COL_LIMIT;
		else if (col_x > scpp_pkg::COL_LIMIT) col_c = scpp_pkg::COL_LIMIT;
		else col_c = col_x;

		if (row_x < -scpp_pkg::ROW_LIMIT) row_c = -scpp_pkg::ROW_LIMIT;
		else if (row_x > scpp_pkg::ROW_LIMIT) row_c = scpp_pkg::ROW_LIMIT;
		else row_c = row_x;

		p1 = scpp_pkg::PULSE_MID + scpp_pkg::CALC_W'(col_c * scpp_pkg::PULSE_STEP);
		p2 = scpp_pkg::PULSE_MID - scpp_pkg::CALC_W'(row_c * scpp_pkg::PULSE_STEP);

		if (p1 < scpp_pkg::PULSE1_MIN) p1_c = scpp_pkg::PULSE1_MIN;
		else if (p1 > scpp_pkg::PULSE1_MAX) p1_c = scpp_pkg::PULSE1_MAX;
		else p1_c = p1;

		if (p2 < scpp_pkg::PULSE2_MIN) p2_c = scpp_pkg::PULSE2_MIN;
		else if (p2 > scpp_pkg::PULSE2_MAX) p2_c = scpp_pkg::PULSE2_MAX;
		else p2_c = p2;
	end

	assign servo1_pulse = p1_c[scpp_pkg::PULSE_W-1:0];
	assign servo2_pulse = p2_c[scpp_pkg::PULSE_W-1:0];
endmodule
`default_nettype wire

// ----- hw/rtl/servo_command_packet_parser_top.sv -----
// Top level: servo command frame parser with stream input and output.
//
// Input stream: one received serial byte per beat on s_axis_tdata. The parser
// looks for six-byte frames (header 0xAA, type 0x01, column, row, checksum,
// tail 0x55). A good frame produces one output beat carrying the raw column
// and row bytes and the two servo pulse widths; a bad frame produces nothing.
// A tail byte accepted into the input register is checked there by the frame
// tracker and, once the output register is free, loads the result register,
// which raises m_axis_tvalid (one input register, then the result register).
// Throughput: one byte per cycle, unless a completing tail byte waits for the
// output register; the frame tracker updates between the two registers.
// Reset (arst_n low, asynchronous) drops both registers and returns the tracker
// to header search with cleared frame bytes.
// Stall: while a result waits in the output register, bytes that close no frame
// keep flowing; only a completing tail byte holds in the input register until
// the output register frees, and s_axis_tready drops behind it.
`default_nettype none
`include "servo_command_packet_parser_top_defines.svh"
module servo_command_packet_parser_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [39:0]      m_axis_tdata    // [7:0] column, [15:8] row,
	                                         // [26:16] servo1_pulse,
	                                         // [37:27] servo2_pulse, [39:38] zero
);
	logic                          valid_s1;
	logic [7:0]                    byte_s1;
	logic                          out_free;
	logic                          adv_s1;
	logic                          produce;
	scpp_pkg::frame_res_t          res;
	logic [scpp_pkg::PULSE_W-1:0]  servo1;
	logic [scpp_pkg::PULSE_W-1:0]  servo2;
	logic [39:0]                   tdata_q;
	logic                          tvalid_q;

	// Advance the stage-1 byte unless it closes a frame and the result slot is busy.
	assign out_free      = !tvalid_q || m_axis_tready;
	assign adv_s1        = valid_s1 && (!res.ok || out_free);
	assign produce       = adv_s1 && res.ok;
	assign s_axis_tready = !valid_s1 || adv_s1;

	scpp_frame u_frame (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv_s1),
		.rx_byte (byte_s1),
		.res     (res)
	);

	scpp_pulse u_pulse (
		.column       (res.column),
		.row          (res.row),
		.servo1_pulse (servo1),
		.servo2_pulse (servo2)
	);

	// Input register: load on every accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) byte_s1 <= s_axis_tdata;
	end

	// Result register: hold until taken, reload on a good frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
		end else if (produce) begin
			tvalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (produce) tdata_q <= {2'b00, servo2, servo1, res.row, res.column};
	end

	assign m_axis_tvalid = tvalid_q;
	assign m_axis_tdata  = tdata_q;

	`SCPP_ASSERT(a_s1_hold, clk, arst_n, (valid_s1 && !adv_s1) |=> (valid_s1 && $stable(byte_s1)))
	`SCPP_ASSERT(a_out_from_s1, clk, arst_n, $rose(tvalid_q) |-> $past(valid_s1))
	`SCPP_ASSERT(a_pulse_range, clk, arst_n, tvalid_q |-> (tdata_q[26:16] >= 11'd1000 && tdata_q[26:16] <= 11'd1900 && tdata_q[37:27] >= 11'd1000 && tdata_q[37:27] <= 11'd2000))
endmodule
`default_nettype wire
